/* hw/rtl/pva_pkg.sv */
package pva_pkg;

  localparam int MAG_W = 24;
  localparam int ANG_W = 17;
  localparam int RMAG_W = 25;
  localparam int RDIR_W = 18;
  // cordic datapath: components with 16 fraction bits plus growth headroom
  localparam int XY_W = 44;
  // angles in 2^-16 degree, room for +-360 degrees
  localparam int Z_W = 27;

  localparam logic [25:0] GAIN_Q24 = 26'd10188014;
  localparam logic signed [Z_W-1:0] DEG90 = 27'sd5898240;
  localparam logic signed [Z_W-1:0] DEG180 = 27'sd11796480;
  localparam logic signed [RDIR_W-1:0] QUARTER_RAW = 18'sd11520;
  localparam logic signed [RDIR_W:0] FULL_TURN_RAW = 19'sd46080;
  localparam logic signed [RDIR_W:0] HALF_TURN_RAW = 19'sd23040;

  // operation field codes
  localparam logic OP_BETWEEN = 1'b0;
  localparam logic OP_AXIS    = 1'b1;

  // side info that rides along the pipeline
  typedef struct packed {
    logic                       op;
    logic signed [ANG_W-1:0]    af;
    logic [MAG_W-1:0]           a;
  } side_t;

  function automatic logic signed [Z_W-1:0] atan_tab(input logic [4:0] i);
    logic signed [Z_W-1:0] r;
    case (i)
      5'd0: r = 27'sd2949120;  5'd1: r = 27'sd1740967;
      5'd2: r = 27'sd919879;   5'd3: r = 27'sd466945;
      5'd4: r = 27'sd234379;   5'd5: r = 27'sd117304;
      5'd6: r = 27'sd58666;    5'd7: r = 27'sd29335;
      5'd8: r = 27'sd14668;    5'd9: r = 27'sd7334;
      5'd10: r = 27'sd3667;    5'd11: r = 27'sd1833;
      5'd12: r = 27'sd917;     5'd13: r = 27'sd458;
      5'd14: r = 27'sd229;     5'd15: r = 27'sd115;
      5'd16: r = 27'sd57;      5'd17: r = 27'sd29;
      5'd18: r = 27'sd14;      5'd19: r = 27'sd7;
      5'd20: r = 27'sd4;       5'd21: r = 27'sd2;
      5'd22: r = 27'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/polar_vector_add_core.sv */
// Resultant of two plane vectors in polar form. Each transaction carries
// two magnitudes (8 fraction bits) and angles in 1/128 degree; operation 0
// takes angle_first as the angle between the vectors, operation 1 takes
// both axis angles. A rotation cordic forms b*cos t and b*sin t, a
// vectoring cordic gives magnitude and direction. Fully pipelined: one
// transaction per cycle; the pipeline advances whenever the output
// register is empty or being taken, so out_ready low stalls the whole
// pipe without loss.
module polar_vector_add_core #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [23:0] in_magnitude_first,
  input  logic [23:0] in_magnitude_second,
  input  logic signed [16:0] in_angle_first,
  input  logic signed [16:0] in_angle_second,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [24:0] out_result_magnitude,
  output logic signed [17:0] out_result_direction
);

  localparam int XW = pva_pkg::XY_W;
  localparam int ZW = pva_pkg::Z_W;

  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // ---- stage 1: angle difference (operation 1) or angle_first (operation 0)
  logic s1_v_r;
  pva_pkg::side_t s1_side_r;
  logic [23:0] s1_b_r;
  logic signed [18:0] s1_t_r;
  logic signed [18:0] diff;
  assign diff = (in_operation == pva_pkg::OP_AXIS)
                ? (19'(in_angle_second) - 19'(in_angle_first))
                : 19'(in_angle_first);

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= in_valid;
    if (en) begin
      s1_side_r <= '{op: in_operation, af: in_angle_first, a: in_magnitude_first};
      s1_b_r <= in_magnitude_second;
      s1_t_r <= diff;
    end
  end

  // ---- stage 2: wrap to (-180,180] (diff lies in (-3 turns, 3 turns))
  logic s2_v_r;
  pva_pkg::side_t s2_side_r;
  logic [23:0] s2_b_r;
  logic signed [18:0] s2_t_r, w0, w1;
  always_comb begin
    w0 = s1_t_r;
    if (w0 < 0) w0 = w0 + pva_pkg::FULL_TURN_RAW;
    if (w0 < 0) w0 = w0 + pva_pkg::FULL_TURN_RAW;
    if (w0 < 0) w0 = w0 + pva_pkg::FULL_TURN_RAW;
    if (w0 >= pva_pkg::FULL_TURN_RAW) w0 = w0 - pva_pkg::FULL_TURN_RAW;
    if (w0 >= pva_pkg::FULL_TURN_RAW) w0 = w0 - pva_pkg::FULL_TURN_RAW;
    w1 = (w0 > pva_pkg::HALF_TURN_RAW) ? w0 - pva_pkg::FULL_TURN_RAW : w0;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= s1_v_r;
    if (en) begin
      s2_side_r <= s1_side_r;
      s2_b_r <= s1_b_r;
      s2_t_r <= w1;
    end
  end

  // ---- stage 3: quadrant fold into rotation cordic
  logic signed [ZW-1:0] z0, zr;
  logic signed [XW-1:0] xr;
  always_comb begin
    z0 = ZW'(s2_t_r) <<< 9;
    xr = XW'({s2_b_r, 8'd0});
    zr = z0;
    if (z0 > pva_pkg::DEG90) begin
      xr = -xr;
      zr = z0 - pva_pkg::DEG180;
    end else if (z0 < -pva_pkg::DEG90) begin
      xr = -xr;
      zr = z0 + pva_pkg::DEG180;
    end
  end

  logic rv;
  logic signed [XW-1:0] rx, ry;
  logic signed [ZW-1:0] rz;
  pva_pkg::side_t rside;
  logic rflag;
  logic signed [17:0] rdir;

  pva_cordic #(.STEPS(CORDIC_STEPS), .VECTORING(1'b0)) u_rot (
    .clk, .rst_n, .en, .in_valid(s2_v_r),
    .x_in(xr), .y_in('0), .z_in(zr), .side_in(s2_side_r),
    .flag_in(1'b0), .dir_in('0),
    .out_valid(rv), .x_out(rx), .y_out(ry), .z_out(rz),
    .side_out(rside), .flag_out(rflag), .dir_out(rdir)
  );

  // ---- gain multiply
  logic m1_v_r;
  pva_pkg::side_t m1_side_r;
  logic signed [XW+26:0] m1_bc_r, m1_bs_r;
  always_ff @(posedge clk) begin
    if (!rst_n) m1_v_r <= 1'b0;
    else if (en) m1_v_r <= rv;
    if (en) begin
      m1_side_r <= rside;
      m1_bc_r <= (XW+27)'(rx) * $signed({1'b0, pva_pkg::GAIN_Q24});
      m1_bs_r <= (XW+27)'(ry) * $signed({1'b0, pva_pkg::GAIN_Q24});
    end
  end

  // ---- form x and y
  logic m2_v_r;
  pva_pkg::side_t m2_side_r;
  logic signed [XW-1:0] m2_x_r, m2_y_r;
  logic signed [XW+26:0] bc_rnd, bs_rnd;
  logic signed [XW-1:0] xs;
  assign bc_rnd = (m1_bc_r + (XW+27)'(1 << 23)) >>> 24;
  assign bs_rnd = (m1_bs_r + (XW+27)'(1 << 23)) >>> 24;
  assign xs = XW'({m1_side_r.a, 8'd0}) + XW'(bc_rnd);
  always_ff @(posedge clk) begin
    if (!rst_n) m2_v_r <= 1'b0;
    else if (en) m2_v_r <= m1_v_r;
    if (en) begin
      m2_side_r <= m1_side_r;
      m2_x_r <= xs;
      m2_y_r <= XW'(bs_rnd);
    end
  end

  // ---- vectoring prefold and special direction
  logic signed [XW-1:0] vx, vy;
  logic signed [ZW-1:0] vz;
  logic zero_x;
  logic signed [17:0] sdir;
  always_comb begin
    zero_x = (m2_x_r == '0);
    vx = m2_x_r;
    vy = m2_y_r;
    vz = '0;
    if (m2_x_r < 0) begin
      vz = (m2_y_r >= 0) ? pva_pkg::DEG180 : -pva_pkg::DEG180;
      vx = -m2_x_r;
      vy = -m2_y_r;
    end
    if (m2_y_r > 0) sdir = pva_pkg::QUARTER_RAW;
    else if (m2_y_r < 0) sdir = -pva_pkg::QUARTER_RAW;
    else sdir = (m2_side_r.op == pva_pkg::OP_AXIS) ? 18'sd0 : pva_pkg::QUARTER_RAW;
  end

  logic vv, vflag;
  logic signed [XW-1:0] ox, oy;
  logic signed [ZW-1:0] oz;
  pva_pkg::side_t oside;
  logic signed [17:0] odir;

  pva_cordic #(.STEPS(CORDIC_STEPS), .VECTORING(1'b1)) u_vec (
    .clk, .rst_n, .en, .in_valid(m2_v_r),
    .x_in(vx), .y_in(vy), .z_in(vz), .side_in(m2_side_r),
    .flag_in(zero_x), .dir_in(sdir),
    .out_valid(vv), .x_out(ox), .y_out(oy), .z_out(oz),
    .side_out(oside), .flag_out(vflag), .dir_out(odir)
  );

  // ---- magnitude multiply and direction round, plus angle_first for operation 1
  logic p_v_r;
  logic signed [XW+26:0] p_m_r;
  logic signed [17:0] p_dir_r;
  logic signed [ZW-1:0] zrnd;
  logic signed [XW-1:0] xpos;
  assign zrnd = (oz + ZW'(256)) >>> 9;
  assign xpos = (ox < 0) ? '0 : ox;
  always_ff @(posedge clk) begin
    if (!rst_n) p_v_r <= 1'b0;
    else if (en) p_v_r <= vv;
    if (en) begin
      p_m_r <= (XW+27)'(xpos) * $signed({1'b0, pva_pkg::GAIN_Q24});
      p_dir_r <= (vflag ? odir : 18'(zrnd)) +
                 ((oside.op == pva_pkg::OP_AXIS) ? 18'(oside.af) : 18'sd0);
    end
  end

  // ---- saturate into output register
  logic signed [XW+26:0] mr;
  logic [24:0] mag;
  assign mr = (p_m_r + (XW+27)'(64'h80000000)) >>> 32;
  assign mag = (mr < 0) ? 25'd0 : (mr > (XW+27)'(33554431)) ? 25'h1FFFFFF : mr[24:0];
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= p_v_r;
    if (en) begin
      out_result_magnitude <= mag;
      out_result_direction <= p_dir_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_magnitude))
    else $error("output changed during stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready mismatch");
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    en && p_v_r |=> out_valid)
    else $error("result lost at output");
`endif

endmodule

/* hw/rtl/pva_cordic_stage.sv */
// one registered cordic micro-rotation, rotation or vectoring
module pva_cordic_stage #(
  parameter int STEP = 0,
  parameter bit VECTORING = 1'b0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [pva_pkg::XY_W-1:0]     x_in,
  input  logic signed [pva_pkg::XY_W-1:0]     y_in,
  input  logic signed [pva_pkg::Z_W-1:0]      z_in,
  input  pva_pkg::side_t                      side_in,
  input  logic                                flag_in,
  input  logic signed [pva_pkg::RDIR_W-1:0]   dir_in,
  output logic                                out_valid,
  output logic signed [pva_pkg::XY_W-1:0]     x_out,
  output logic signed [pva_pkg::XY_W-1:0]     y_out,
  output logic signed [pva_pkg::Z_W-1:0]      z_out,
  output pva_pkg::side_t                      side_out,
  output logic                                flag_out,
  output logic signed [pva_pkg::RDIR_W-1:0]   dir_out
);

  logic signed [pva_pkg::XY_W-1:0] dx, dy, x_nxt, y_nxt;
  logic signed [pva_pkg::Z_W-1:0] ang, z_nxt;
  logic pos;

  always_comb begin
    dx = x_in >>> STEP;
    dy = y_in >>> STEP;
    ang = pva_pkg::atan_tab(5'(STEP));
    if (VECTORING) begin
      pos = (y_in > 0);
      x_nxt = pos ? x_in + dy : x_in - dy;
      y_nxt = pos ? y_in - dx : y_in + dx;
      z_nxt = pos ? z_in + ang : z_in - ang;
    end else begin
      pos = (z_in >= 0);
      x_nxt = pos ? x_in - dy : x_in + dy;
      y_nxt = pos ? y_in + dx : y_in - dx;
      z_nxt = pos ? z_in - ang : z_in + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      x_out <= x_nxt;
      y_out <= y_nxt;
      z_out <= z_nxt;
      side_out <= side_in;
      flag_out <= flag_in;
      dir_out <= dir_in;
    end
  end

endmodule

/* hw/rtl/pva_cordic.sv */
// chain of registered cordic stages
module pva_cordic #(
  parameter int STEPS = 24,
  parameter bit VECTORING = 1'b0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [pva_pkg::XY_W-1:0]     x_in,
  input  logic signed [pva_pkg::XY_W-1:0]     y_in,
  input  logic signed [pva_pkg::Z_W-1:0]      z_in,
  input  pva_pkg::side_t                      side_in,
  input  logic                                flag_in,
  input  logic signed [pva_pkg::RDIR_W-1:0]   dir_in,
  output logic                                out_valid,
  output logic signed [pva_pkg::XY_W-1:0]     x_out,
  output logic signed [pva_pkg::XY_W-1:0]     y_out,
  output logic signed [pva_pkg::Z_W-1:0]      z_out,
  output pva_pkg::side_t                      side_out,
  output logic                                flag_out,
  output logic signed [pva_pkg::RDIR_W-1:0]   dir_out
);

  logic                              v [STEPS+1];
  logic signed [pva_pkg::XY_W-1:0]   xs [STEPS+1];
  logic signed [pva_pkg::XY_W-1:0]   ys [STEPS+1];
  logic signed [pva_pkg::Z_W-1:0]    zs [STEPS+1];
  pva_pkg::side_t                    ss [STEPS+1];
  logic                              fs [STEPS+1];
  logic signed [pva_pkg::RDIR_W-1:0] ds [STEPS+1];

  assign v[0] = in_valid;
  assign xs[0] = x_in;
  assign ys[0] = y_in;
  assign zs[0] = z_in;
  assign ss[0] = side_in;
  assign fs[0] = flag_in;
  assign ds[0] = dir_in;

  for (genvar g = 0; g < STEPS; g++) begin : g_stage
    pva_cordic_stage #(.STEP(g), .VECTORING(VECTORING)) u_stage (
      .clk, .rst_n, .en,
      .in_valid(v[g]), .x_in(xs[g]), .y_in(ys[g]), .z_in(zs[g]),
      .side_in(ss[g]), .flag_in(fs[g]), .dir_in(ds[g]),
      .out_valid(v[g+1]), .x_out(xs[g+1]), .y_out(ys[g+1]), .z_out(zs[g+1]),
      .side_out(ss[g+1]), .flag_out(fs[g+1]), .dir_out(ds[g+1])
    );
  end

  assign out_valid = v[STEPS];
  assign x_out = xs[STEPS];
  assign y_out = ys[STEPS];
  assign z_out = zs[STEPS];
  assign side_out = ss[STEPS];
  assign flag_out = fs[STEPS];
  assign dir_out = ds[STEPS];

endmodule
